### rtl/i2c_master_packet_sequencer_assert.svh
// assertion macros shared by the checker of the i2c packet sequencer
// depends on: nothing; the user supplies clk and rst_n in scope
`ifndef I2C_MASTER_PACKET_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_PACKET_SEQUENCER_ASSERT_SVH

// property sampled on clk, switched off while reset is held
`define I2CMPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property sampled on clk that also holds across reset
`define I2CMPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/i2cmps_pkg.sv
// shared types and codes of the i2c master packet sequencer
// depends on: nothing
package i2cmps_pkg;

  // word buffer geometry
  localparam int MAX_PAIRS  = 16;
  localparam int SLOT_COUNT = 16;

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_START_WR  = 2'd1,
    OP_START_RD  = 2'd2,
    OP_BUS_EVENT = 2'd3
  } opcode_t;

  // bus actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_RSTART = 3'd2;
  localparam logic [2:0] ACT_STOP   = 3'd3;
  localparam logic [2:0] ACT_TX     = 3'd4;
  localparam logic [2:0] ACT_RCEN   = 3'd5;
  localparam logic [2:0] ACT_ACK    = 3'd6;

  // packet status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BUSY        = 3'd1;
  localparam logic [2:0] ST_NOT_IDLE    = 3'd2;
  localparam logic [2:0] ST_NO_ADR_ACK  = 3'd3;
  localparam logic [2:0] ST_NO_DATA_ACK = 3'd4;

  typedef struct packed {
    opcode_t    opcode;
    logic [3:0] word_index;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [6:0] slave_address;
    logic [3:0] command_code;
    logic [3:0] pair_count;
    logic       ack_missing;
    logic       write_collision;
    logic       start_seen;
    logic       stop_seen;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [3:0] rx_word;
    logic       rx_is_second;
    logic [2:0] status;
    logic       done_res;
  } result_t;

endpackage

### rtl/i2cmps_core.sv
// packet state machine and word buffer of the i2c master sequencer
// depends on: i2cmps_pkg
module i2cmps_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  i2cmps_pkg::item_t item,
  output i2cmps_pkg::result_t res
);
  import i2cmps_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_WAIT_START    = 4'd1,
    PH_CHK_ADDR      = 4'd2,
    PH_CHK_CMD       = 4'd3,
    PH_CHK_FIRST     = 4'd4,
    PH_CHK_SECOND    = 4'd5,
    PH_CHK_REP       = 4'd6,
    PH_EN_RX         = 4'd7,
    PH_RX_FIRST      = 4'd8,
    PH_RX_FIRST_ACK  = 4'd9,
    PH_RX_SECOND     = 4'd10,
    PH_RX_SECOND_ACK = 4'd11,
    PH_STOP          = 4'd12
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       read_mode_r, read_mode_nxt;
  logic       first_packet_r, first_packet_nxt;
  logic       busy_r, busy_nxt;
  logic [3:0] pair_index_r, pair_index_nxt;
  logic [6:0] held_address_r, held_address_nxt;
  logic [3:0] held_command_r, held_command_nxt;
  logic [3:0] held_count_r, held_count_nxt;
  logic [2:0] pkt_status_r, pkt_status_nxt;

  logic [15:0] word_buf_r [SLOT_COUNT];

  logic [3:0] pidx_inc;
  logic       more_pairs;
  logic [3:0] rd_idx;
  logic       rd_in_range;
  logic [7:0] slot_hi;
  logic [7:0] slot_lo;
  logic       bad;
  logic       load_en;

  // next pair index and whether another pair follows
  assign pidx_inc   = pair_index_r + 4'd1;
  assign more_pairs = (pidx_inc != 4'd0) && (pidx_inc < held_count_r);
  assign bad        = item.ack_missing | item.write_collision;

  // single buffer read port, advanced index when leaving the second byte
  assign rd_idx      = (phase_r == PH_CHK_SECOND) ? pidx_inc : pair_index_r;
  assign rd_in_range = {1'b0, rd_idx} < 5'(MAX_PAIRS);
  assign slot_hi     = rd_in_range ? word_buf_r[rd_idx][15:8] : 8'h00;
  assign slot_lo     = rd_in_range ? word_buf_r[rd_idx][7:0] : 8'h00;

  assign load_en = step && (item.opcode == OP_LOAD) &&
                   ({1'b0, item.word_index} < 5'(MAX_PAIRS));

  // one sequencing step per item
  always_comb begin
    res              = '0;
    phase_nxt        = phase_r;
    read_mode_nxt    = read_mode_r;
    first_packet_nxt = first_packet_r;
    busy_nxt         = busy_r;
    pair_index_nxt   = pair_index_r;
    held_address_nxt = held_address_r;
    held_command_nxt = held_command_r;
    held_count_nxt   = held_count_r;
    pkt_status_nxt   = pkt_status_r;

    case (item.opcode)
      OP_LOAD: begin
      end
      OP_START_WR, OP_START_RD: begin
        if (busy_r) begin
          res.status = ST_BUSY;
        end else if (first_packet_r || (!item.start_seen && item.stop_seen)) begin
          first_packet_nxt = 1'b0;
          read_mode_nxt    = (item.opcode == OP_START_RD);
          held_address_nxt = item.slave_address;
          held_command_nxt = item.command_code;
          held_count_nxt   = item.pair_count;
          pair_index_nxt   = 4'd0;
          pkt_status_nxt   = ST_OK;
          busy_nxt         = 1'b1;
          phase_nxt        = PH_WAIT_START;
          res.action       = ACT_START;
        end else begin
          res.status   = ST_NOT_IDLE;
          res.done_res = 1'b1;
        end
      end
      default: begin
        // bus event
        case (phase_r)
          PH_IDLE: begin
          end
          PH_WAIT_START: begin
            if (item.start_seen && !item.stop_seen) begin
              res.action  = ACT_TX;
              res.tx_byte = {held_address_r, 1'b0};
              phase_nxt   = PH_CHK_ADDR;
            end else begin
              res.action     = ACT_STOP;
              pkt_status_nxt = read_mode_r ? ST_NO_ADR_ACK : ST_NOT_IDLE;
              phase_nxt      = PH_STOP;
            end
          end
          PH_CHK_ADDR: begin
            if (bad) begin
              res.action     = ACT_STOP;
              pkt_status_nxt = ST_NO_ADR_ACK;
              phase_nxt      = PH_STOP;
            end else begin
              res.action  = ACT_TX;
              res.tx_byte = {held_count_r, held_command_r};
              phase_nxt   = PH_CHK_CMD;
            end
          end
          PH_CHK_CMD: begin
            if (bad) begin
              res.action     = ACT_STOP;
              pkt_status_nxt = ST_NO_DATA_ACK;
              phase_nxt      = PH_STOP;
            end else if (read_mode_r) begin
              res.action = ACT_RSTART;
              phase_nxt  = PH_CHK_REP;
            end else begin
              res.action  = ACT_TX;
              res.tx_byte = slot_hi;
              phase_nxt   = PH_CHK_FIRST;
            end
          end
          PH_CHK_FIRST: begin
            if (bad) begin
              res.action     = ACT_STOP;
              pkt_status_nxt = ST_NO_DATA_ACK;
              phase_nxt      = PH_STOP;
            end else begin
              res.action  = ACT_TX;
              res.tx_byte = slot_lo;
              phase_nxt   = PH_CHK_SECOND;
            end
          end
          PH_CHK_SECOND: begin
            if (bad) begin
              res.action     = ACT_STOP;
              pkt_status_nxt = ST_NO_DATA_ACK;
              phase_nxt      = PH_STOP;
            end else begin
              pair_index_nxt = pidx_inc;
              if (more_pairs) begin
                res.action  = ACT_TX;
                res.tx_byte = slot_hi;
                phase_nxt   = PH_CHK_FIRST;
              end else begin
                res.action = ACT_STOP;
                phase_nxt  = PH_STOP;
              end
            end
          end
          PH_CHK_REP: begin
            res.action  = ACT_TX;
            res.tx_byte = {held_address_r, 1'b1};
            phase_nxt   = PH_EN_RX;
          end
          PH_EN_RX: begin
            res.action = ACT_RCEN;
            phase_nxt  = PH_RX_FIRST;
          end
          PH_RX_FIRST: begin
            res.action   = ACT_ACK;
            res.rx_valid = 1'b1;
            res.rx_data  = item.rx_byte;
            res.rx_word  = pair_index_r;
            phase_nxt    = PH_RX_FIRST_ACK;
          end
          PH_RX_FIRST_ACK: begin
            res.action = ACT_RCEN;
            phase_nxt  = PH_RX_SECOND;
          end
          PH_RX_SECOND: begin
            // nack after the last pair
            res.action       = ACT_ACK;
            res.rx_valid     = 1'b1;
            res.rx_data      = item.rx_byte;
            res.rx_word      = pair_index_r;
            res.rx_is_second = 1'b1;
            res.ack_level    = !more_pairs;
            pair_index_nxt   = pidx_inc;
            phase_nxt        = PH_RX_SECOND_ACK;
          end
          PH_RX_SECOND_ACK: begin
            if ((pair_index_r != 4'd0) && (pair_index_r < held_count_r)) begin
              res.action = ACT_RCEN;
              phase_nxt  = PH_RX_FIRST;
            end else begin
              res.action = ACT_STOP;
              phase_nxt  = PH_STOP;
            end
          end
          PH_STOP: begin
            res.status   = pkt_status_r;
            res.done_res = 1'b1;
            phase_nxt    = PH_IDLE;
            busy_nxt     = 1'b0;
          end
          default: begin
            phase_nxt = PH_IDLE;
            busy_nxt  = 1'b0;
          end
        endcase
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      read_mode_r    <= 1'b0;
      first_packet_r <= 1'b1;
      busy_r         <= 1'b0;
      pair_index_r   <= 4'd0;
      held_address_r <= 7'd0;
      held_command_r <= 4'd0;
      held_count_r   <= 4'd0;
      pkt_status_r   <= ST_OK;
    end else if (step) begin
      phase_r        <= phase_nxt;
      read_mode_r    <= read_mode_nxt;
      first_packet_r <= first_packet_nxt;
      busy_r         <= busy_nxt;
      pair_index_r   <= pair_index_nxt;
      held_address_r <= held_address_nxt;
      held_command_r <= held_command_nxt;
      held_count_r   <= held_count_nxt;
      pkt_status_r   <= pkt_status_nxt;
    end
  end

  // word buffer, no reset
  always_ff @(posedge clk) begin
    if (load_en) begin
      word_buf_r[item.word_index] <= {item.first_byte, item.second_byte};
    end
  end

endmodule

### rtl/i2c_master_packet_sequencer.sv
// top level of the i2c master packet sequencer: input and result registers
// depends on: i2cmps_pkg, i2cmps_core
//
//   channel | ports                      | moves
//   in      | in_valid / in_stall / in_*  | one request or bus event word
//   out     | out_valid / out_stall / out_* | one action and status word
//
// the input register holds the word, the result register holds its result
// throughput: one word per cycle unless stalled; a single registered state step
// reset: synchronous active-low rst_n clears both valid flags and the state
// a stalled output holds its word; the input register keeps taking a word while
// the output register drains
module i2c_master_packet_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_word_index,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic [6:0] in_slave_address,
  input  logic [3:0] in_command_code,
  input  logic [3:0] in_pair_count,
  input  logic       in_ack_missing,
  input  logic       in_write_collision,
  input  logic       in_start_seen,
  input  logic       in_stop_seen,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_action,
  output logic [7:0] out_tx_byte,
  output logic       out_ack_level,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_data,
  output logic [3:0] out_rx_word,
  output logic       out_rx_is_second,
  output logic [2:0] out_status,
  output logic       out_done_res
);
  import i2cmps_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  result_t core_res;
  logic    advance;
  logic    in_take;
  logic    step;

  // pipeline control
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign step     = in_valid_r && advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{opcode:          opcode_t'(in_opcode),
                  word_index:      in_word_index,
                  first_byte:      in_first_byte,
                  second_byte:     in_second_byte,
                  slave_address:   in_slave_address,
                  command_code:    in_command_code,
                  pair_count:      in_pair_count,
                  ack_missing:     in_ack_missing,
                  write_collision: in_write_collision,
                  start_seen:      in_start_seen,
                  stop_seen:       in_stop_seen,
                  rx_byte:         in_rx_byte};
    end
  end

  i2cmps_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .res   (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = res_r.action;
  assign out_tx_byte      = res_r.tx_byte;
  assign out_ack_level    = res_r.ack_level;
  assign out_rx_valid     = res_r.rx_valid;
  assign out_rx_data      = res_r.rx_data;
  assign out_rx_word      = res_r.rx_word;
  assign out_rx_is_second = res_r.rx_is_second;
  assign out_status       = res_r.status;
  assign out_done_res     = res_r.done_res;

endmodule

### rtl/i2cmps_checker.sv
// port-level checks of the i2c master packet sequencer, bound to the top level
// depends on: i2cmps_pkg, i2c_master_packet_sequencer_assert.svh
`include "i2c_master_packet_sequencer_assert.svh"

module i2cmps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_action,
  input logic [7:0] out_tx_byte,
  input logic       out_rx_valid,
  input logic       out_done_res
);
  import i2cmps_pkg::*;

  // a stalled result word stays offered
  `I2CMPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

  // reset empties the result register
  `I2CMPS_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

  // received bytes only come with an acknowledge action
  `I2CMPS_ASSERT(a_rx_ack, out_valid && out_rx_valid |-> out_action == ACT_ACK, "rx byte without ack")

  // a finished packet drives no bus action
  `I2CMPS_ASSERT(a_done_idle, out_valid && out_done_res |-> out_action == ACT_NONE, "done with action")

  // transmit byte is zero unless transmitting
  `I2CMPS_ASSERT(a_tx_zero, out_valid && out_action != ACT_TX |-> out_tx_byte == 8'h00, "stray tx byte")

endmodule

bind i2c_master_packet_sequencer i2cmps_checker u_i2cmps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_action   (out_action),
  .out_tx_byte  (out_tx_byte),
  .out_rx_valid (out_rx_valid),
  .out_done_res (out_done_res)
);

### test/testbench.sv
// self-checking testbench of the i2c master packet sequencer: directed and random packets
// depends on: i2cmps_pkg and i2c_master_packet_sequencer from the rtl folder
module testbench;
  import i2cmps_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_WORDS = 450;

  // sequencing steps of one packet
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_WAIT_START, SEQ_CHK_ADDR, SEQ_CHK_CMD, SEQ_CHK_FIRST,
    SEQ_CHK_SECOND, SEQ_CHK_REP, SEQ_EN_RX, SEQ_RX_FIRST, SEQ_RX_FIRST_ACK,
    SEQ_RX_SECOND, SEQ_RX_SECOND_ACK, SEQ_STOP
  } seq_step_t;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_action;
  logic [7:0] out_tx_byte;
  logic out_ack_level;
  logic out_rx_valid;
  logic [7:0] out_rx_data;
  logic [3:0] out_rx_word;
  logic out_rx_is_second;
  logic [2:0] out_status;
  logic out_done_res;

  // word on the input port, held while stalled
  item_t drv = '0;

  // words waiting to be sent, with a flag to hold off until all results are in
  item_t bus_requests[$];
  bit wait_for_idle[$];
  result_t expected_actions[$];

  // sequencer state as predicted
  seq_step_t seq = SEQ_IDLE;
  logic rd_packet = 1'b0;
  logic first_after_reset = 1'b1;
  logic packet_open = 1'b0;
  logic [3:0] pair_pos = '0;
  logic [6:0] addr_held = '0;
  logic [3:0] cmd_held = '0;
  logic [3:0] count_held = '0;
  logic [2:0] abort_code = ST_OK;
  logic [15:0] pair_store[16];

  int cycle_count = 0;
  int sent_count = 0;
  int result_count = 0;
  int mismatch_count = 0;
  int run_left = 1;
  int gap_left = 0;
  result_t seen;
  result_t want;

  i2c_master_packet_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(drv.opcode),
    .in_word_index(drv.word_index),
    .in_first_byte(drv.first_byte),
    .in_second_byte(drv.second_byte),
    .in_slave_address(drv.slave_address),
    .in_command_code(drv.command_code),
    .in_pair_count(drv.pair_count),
    .in_ack_missing(drv.ack_missing),
    .in_write_collision(drv.write_collision),
    .in_start_seen(drv.start_seen),
    .in_stop_seen(drv.stop_seen),
    .in_rx_byte(drv.rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_action(out_action),
    .out_tx_byte(out_tx_byte),
    .out_ack_level(out_ack_level),
    .out_rx_valid(out_rx_valid),
    .out_rx_data(out_rx_data),
    .out_rx_word(out_rx_word),
    .out_rx_is_second(out_rx_is_second),
    .out_status(out_status),
    .out_done_res(out_done_res)
  );

  // clock and a single reset pulse
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] stored_byte(logic [3:0] idx, bit second);
    if (int'(idx) >= MAX_PAIRS) return 8'h00;
    return second ? pair_store[idx][7:0] : pair_store[idx][15:8];
  endfunction

  function automatic bit more_pairs();
    return pair_pos != 4'd0 && pair_pos < count_held;
  endfunction

  function automatic logic [2:0] abort_packet(logic [2:0] code);
    abort_code = code;
    seq = SEQ_STOP;
    return ACT_STOP;
  endfunction

  // one input word in, one action and status word out
  function automatic result_t sequence_step(item_t w);
    result_t r;
    logic fault;
    r = '0;
    fault = w.ack_missing | w.write_collision;
    case (w.opcode)
      OP_LOAD: begin
        if (int'(w.word_index) < MAX_PAIRS) pair_store[w.word_index] = {w.first_byte, w.second_byte};
      end
      OP_START_WR, OP_START_RD: begin
        if (packet_open) begin
          r.status = ST_BUSY;
        end else if (first_after_reset || (w.stop_seen && !w.start_seen)) begin
          // bus check is skipped for the very first packet
          first_after_reset = 1'b0;
          rd_packet = (w.opcode == OP_START_RD);
          addr_held = w.slave_address;
          cmd_held = w.command_code;
          count_held = w.pair_count;
          pair_pos = '0;
          abort_code = ST_OK;
          packet_open = 1'b1;
          seq = SEQ_WAIT_START;
          r.action = ACT_START;
        end else begin
          r.status = ST_NOT_IDLE;
          r.done_res = 1'b1;
        end
      end
      default: begin
        case (seq)
          SEQ_IDLE: ;
          SEQ_WAIT_START: begin
            if (w.start_seen && !w.stop_seen) begin
              r.action = ACT_TX;
              r.tx_byte = {addr_held, 1'b0};
              seq = SEQ_CHK_ADDR;
            end else begin
              r.action = abort_packet(rd_packet ? ST_NO_ADR_ACK : ST_NOT_IDLE);
            end
          end
          SEQ_CHK_ADDR: begin
            if (fault) begin
              r.action = abort_packet(ST_NO_ADR_ACK);
            end else begin
              r.action = ACT_TX;
              r.tx_byte = {count_held, cmd_held};
              seq = SEQ_CHK_CMD;
            end
          end
          SEQ_CHK_CMD: begin
            if (fault) begin
              r.action = abort_packet(ST_NO_DATA_ACK);
            end else if (rd_packet) begin
              r.action = ACT_RSTART;
              seq = SEQ_CHK_REP;
            end else begin
              r.action = ACT_TX;
              r.tx_byte = stored_byte(pair_pos, 1'b0);
              seq = SEQ_CHK_FIRST;
            end
          end
          SEQ_CHK_FIRST: begin
            if (fault) begin
              r.action = abort_packet(ST_NO_DATA_ACK);
            end else begin
              r.action = ACT_TX;
              r.tx_byte = stored_byte(pair_pos, 1'b1);
              seq = SEQ_CHK_SECOND;
            end
          end
          SEQ_CHK_SECOND: begin
            if (fault) begin
              r.action = abort_packet(ST_NO_DATA_ACK);
            end else begin
              pair_pos = pair_pos + 4'd1;
              if (more_pairs()) begin
                r.action = ACT_TX;
                r.tx_byte = stored_byte(pair_pos, 1'b0);
                seq = SEQ_CHK_FIRST;
              end else begin
                r.action = ACT_STOP;
                seq = SEQ_STOP;
              end
            end
          end
          SEQ_CHK_REP: begin
            // read address is sent without an ack check
            r.action = ACT_TX;
            r.tx_byte = {addr_held, 1'b1};
            seq = SEQ_EN_RX;
          end
          SEQ_EN_RX: begin
            r.action = ACT_RCEN;
            seq = SEQ_RX_FIRST;
          end
          SEQ_RX_FIRST: begin
            r.action = ACT_ACK;
            r.rx_valid = 1'b1;
            r.rx_data = w.rx_byte;
            r.rx_word = pair_pos;
            seq = SEQ_RX_FIRST_ACK;
          end
          SEQ_RX_FIRST_ACK: begin
            r.action = ACT_RCEN;
            seq = SEQ_RX_SECOND;
          end
          SEQ_RX_SECOND: begin
            // nack after the last pair only
            r.action = ACT_ACK;
            r.rx_valid = 1'b1;
            r.rx_data = w.rx_byte;
            r.rx_word = pair_pos;
            r.rx_is_second = 1'b1;
            pair_pos = pair_pos + 4'd1;
            r.ack_level = !more_pairs();
            seq = SEQ_RX_SECOND_ACK;
          end
          SEQ_RX_SECOND_ACK: begin
            if (more_pairs()) begin
              r.action = ACT_RCEN;
              seq = SEQ_RX_FIRST;
            end else begin
              r.action = ACT_STOP;
              seq = SEQ_STOP;
            end
          end
          SEQ_STOP: begin
            r.status = abort_code;
            r.done_res = 1'b1;
            seq = SEQ_IDLE;
            packet_open = 1'b0;
          end
          default: begin
            seq = SEQ_IDLE;
            packet_open = 1'b0;
          end
        endcase
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus words

  function automatic item_t random_word();
    item_t w;
    w.opcode = opcode_t'(2'($urandom_range(0, 3)));
    w.word_index = 4'($urandom_range(0, 15));
    w.first_byte = 8'($urandom_range(0, 255));
    w.second_byte = 8'($urandom_range(0, 255));
    w.slave_address = 7'($urandom_range(0, 127));
    w.command_code = 4'($urandom_range(0, 15));
    w.pair_count = 4'($urandom_range(0, 15));
    w.ack_missing = 1'($urandom_range(0, 1));
    w.write_collision = 1'($urandom_range(0, 1));
    w.start_seen = 1'($urandom_range(0, 1));
    w.stop_seen = 1'($urandom_range(0, 1));
    w.rx_byte = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic item_t load_word(logic [3:0] idx, logic [7:0] hi, logic [7:0] lo);
    item_t w;
    w = random_word();
    w.opcode = OP_LOAD;
    w.word_index = idx;
    w.first_byte = hi;
    w.second_byte = lo;
    return w;
  endfunction

  function automatic item_t start_word(bit rd, logic [6:0] addr, logic [3:0] cmd,
                                       logic [3:0] cnt, bit s, bit p);
    item_t w;
    w = random_word();
    w.opcode = rd ? OP_START_RD : OP_START_WR;
    w.slave_address = addr;
    w.command_code = cmd;
    w.pair_count = cnt;
    w.start_seen = s;
    w.stop_seen = p;
    return w;
  endfunction

  function automatic item_t bus_word(bit s, bit p, bit nack, bit wcol, logic [7:0] rx);
    item_t w;
    w = random_word();
    w.opcode = OP_BUS_EVENT;
    w.start_seen = s;
    w.stop_seen = p;
    w.ack_missing = nack;
    w.write_collision = wcol;
    w.rx_byte = rx;
    return w;
  endfunction

  task automatic push_word(item_t w, bit hold);
    bus_requests.push_back(w);
    wait_for_idle.push_back(hold);
  endtask

  // mostly loads and bus events, now and then a start
  function automatic item_t noise_word();
    item_t w;
    int pick;
    w = random_word();
    pick = $urandom_range(0, 7);
    if (pick < 3) w.opcode = OP_LOAD;
    else if (pick == 3) w.opcode = $urandom_range(0, 1) ? OP_START_RD : OP_START_WR;
    else w.opcode = OP_BUS_EVENT;
    return w;
  endfunction

  // one packet: start, the bus events it needs, optionally one fault, then the closing event
  task automatic queue_packet(bit rd, bit clean, bit hold);
    logic [3:0] cnt;
    logic [1:0] sp;
    logic [1:0] errs;
    int pairs;
    int events;
    int bad_at;
    bit chk;
    cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 4));
    pairs = (cnt == 0) ? 1 : int'(cnt);
    events = rd ? 4 * pairs + 5 : 2 * pairs + 3;
    bad_at = clean ? -1 : int'($urandom_range(0, rd ? 2 : events - 1));
    push_word(start_word(rd, 7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)), cnt,
                         1'b0, 1'b1),
              hold);
    for (int k = 0; k < events; k++) begin
      // stray load or rejected start in the middle of a packet
      if ($urandom_range(0, 15) == 0) begin
        push_word($urandom_range(0, 1) ? load_word(4'($urandom_range(0, 15)),
                                                   8'($urandom_range(0, 255)),
                                                   8'($urandom_range(0, 255)))
                                       : start_word(1'($urandom_range(0, 1)),
                                                    7'($urandom_range(0, 127)),
                                                    4'($urandom_range(0, 15)),
                                                    4'($urandom_range(0, 15)),
                                                    1'($urandom_range(0, 1)),
                                                    1'($urandom_range(0, 1))),
                  1'b0);
      end
      chk = (k >= 1) && (!rd || k <= 2);
      if (k == bad_at) begin
        if (k == 0) begin
          sp = 2'($urandom_range(0, 3));
          if (sp == 2'b10) sp = 2'b00;
          push_word(bus_word(sp[1], sp[0], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255))), 1'b0);
        end else begin
          errs = 2'($urandom_range(1, 3));
          push_word(bus_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), errs[1],
                             errs[0], 8'($urandom_range(0, 255))), 1'b0);
        end
        break;
      end
      if (k == 0) begin
        push_word(bus_word(1'b1, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255))), 1'b0);
      end else begin
        push_word(bus_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           chk ? 1'b0 : 1'($urandom_range(0, 1)),
                           chk ? 1'b0 : 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255))), 1'b0);
      end
    end
    // event that closes the packet
    push_word(bus_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255))), 1'b0);
  endtask

  initial begin : stimulus
    int base;
    int total;
    // directed: slot extremes, idle event, first packet without bus check
    push_word(load_word(4'd0, 8'hFF, 8'h00), 1'b0);
    push_word(load_word(4'd15, 8'h00, 8'hFF), 1'b0);
    push_word(bus_word(1'b1, 1'b0, 1'b0, 1'b0, 8'hA5), 1'b0);
    push_word(start_word(1'b0, 7'h7F, 4'hF, 4'd0, 1'b1, 1'b0), 1'b0);
    push_word(start_word(1'b1, 7'h00, 4'h0, 4'd15, 1'b0, 1'b1), 1'b0);
    for (int k = 0; k < 5; k++) push_word(bus_word(1'b1, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0);
    push_word(bus_word(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF), 1'b0);
    // busy bus rejects the start, then a one-pair read
    push_word(start_word(1'b0, 7'h55, 4'h5, 4'd1, 1'b1, 1'b1), 1'b0);
    push_word(start_word(1'b1, 7'h00, 4'h0, 4'd1, 1'b0, 1'b1), 1'b0);
    for (int k = 0; k < 9; k++) begin
      push_word(bus_word(1'b1, 1'b0, 1'b0, 1'b0, k[0] ? 8'h00 : 8'hFF), 1'b0);
    end
    push_word(bus_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00), 1'b0);

    // random: fill every slot, then mostly well-formed packets with noise between
    base = bus_requests.size();
    for (int i = 0; i < 16; i++) begin
      push_word(load_word(4'(i), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))),
                i == 0);
    end
    while (bus_requests.size() - base < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) push_word(noise_word(), 1'b0);
      end
      if ($urandom_range(0, 9) == 0) begin
        push_word(start_word(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1,
                             1'($urandom_range(0, 1))),
                  $urandom_range(0, 9) == 0);
      end else begin
        queue_packet(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                     $urandom_range(0, 9) == 0);
      end
    end
    total = bus_requests.size();

    // wait until every word is taken and its result checked, then drain before the verdict
    @(posedge rst_n);
    while (sent_count != total || expected_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_actions.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // word taken: predict its result and plan the burst
      if (in_valid && !in_stall) begin
        expected_actions.push_back(sequence_step(drv));
        sent_count++;
        if (run_left > 1) begin
          run_left--;
        end else begin
          run_left = $urandom_range(1, 16);
          gap_left = ((sent_count / 96) % 3 == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      // next word, unless in a gap or holding off for the results to drain
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bus_requests.size() != 0 &&
                     !(wait_for_idle[0] && expected_actions.size() != 0)) begin
          drv <= bus_requests.pop_front();
          void'(wait_for_idle.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string fname, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result %0d %s: expected %0h, got %0h", result_count, fname, exp_val, got_val);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_action, out_tx_byte, out_ack_level, out_rx_valid, out_rx_data, out_rx_word,
              out_rx_is_second, out_status, out_done_res};
      result_count++;
      if (expected_actions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result %0d with none expected: %h", result_count, seen);
      end else begin
        want = expected_actions.pop_front();
        check_field("action", want.action, seen.action);
        check_field("tx_byte", want.tx_byte, seen.tx_byte);
        check_field("ack_level", want.ack_level, seen.ack_level);
        check_field("rx_valid", want.rx_valid, seen.rx_valid);
        check_field("rx_data", want.rx_data, seen.rx_data);
        check_field("rx_word", want.rx_word, seen.rx_word);
        check_field("rx_is_second", want.rx_is_second, seen.rx_is_second);
        check_field("status", want.status, seen.status);
        check_field("done_res", want.done_res, seen.done_res);
      end
    end
    // receiver stall pattern: none, light random, heavy random, periodic
    case ((cycle_count / 300) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycle_count % 7) < 3);
    endcase
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

endmodule
